// ----- src/usd_pkg.sv -----
// Shared types, constants and the lead byte classifier for the UTF-8 stream decoder.
// Used by every module of the decoder; depends on nothing else.

package usd_pkg;

  // default depth of the queue between front and back
  localparam int QueueDepthDefault = 4;

  // lead byte masks and patterns
  localparam logic [7:0] AsciiMask   = 8'h80;
  localparam logic [7:0] LeadTwoMask = 8'hE0;
  localparam logic [7:0] LeadTwoPat  = 8'hC0;
  localparam logic [7:0] LeadThrMask = 8'hF0;
  localparam logic [7:0] LeadThrPat  = 8'hE0;
  localparam logic [7:0] LeadFourMsk = 8'hF8;
  localparam logic [7:0] LeadFourPat = 8'hF0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } octet_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        has_code_point;
    logic        string_error;
    logic        end_of_string;
  } result_t;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_ZERO,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_class_t;

  // one classified byte as it travels through the queue
  typedef struct packed {
    octet_t      octet;
    lead_class_t lead;
  } token_t;

  // class of a byte, were it to stand at a lead position
  function automatic lead_class_t classify(input logic [7:0] b);
    lead_class_t c;
    if (b == 8'h00)                             c = LEAD_ZERO;
    else if ((b & AsciiMask) == 8'h00)          c = LEAD_ASCII;
    else if ((b & LeadTwoMask) == LeadTwoPat)   c = LEAD_TWO;
    else if ((b & LeadThrMask) == LeadThrPat)   c = LEAD_THREE;
    else if ((b & LeadFourMsk) == LeadFourPat)  c = LEAD_FOUR;
    else                                        c = LEAD_BAD;
    return c;
  endfunction

endpackage

// ----- src/usd_front.sv -----
// Front end: accepts input bytes and classifies them for the back end.
// Depends on usd_pkg; feeds usd_queue.

module usd_front (
  input  logic            octet_valid,
  output logic            octet_stall,
  input  usd_pkg::octet_t octet,
  input  logic            queue_full,
  output logic            push,
  output usd_pkg::token_t push_token
);
  import usd_pkg::*;

  // hold the producer while the queue has no room
  assign octet_stall = queue_full;
  assign push        = octet_valid && !queue_full;

  // tag each byte with its lead class
  always_comb begin
    push_token.octet = octet;
    push_token.lead  = classify(octet.in_byte);
  end

endmodule

// ----- src/usd_queue.sv -----
// Short first-in first-out queue of classified bytes between front and back.
// Depends on usd_pkg.

module usd_queue #(
  parameter int Depth = usd_pkg::QueueDepthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  usd_pkg::token_t push_token,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output usd_pkg::token_t head_token
);
  import usd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  token_t            slots [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic [PtrW-1:0]   wr_ptr_next;
  logic [PtrW-1:0]   rd_ptr_next;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_token = slots[rd_ptr];

  // advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_next = (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
    rd_ptr_next = (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
  end

  // store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_token;
    end
  end

  // track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr_next;
      if (pop)  rd_ptr <= rd_ptr_next;
      if (push && !pop)      count <= count + CntW'(1);
      else if (pop && !push) count <= count - CntW'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue occupancy beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("pop from an empty queue");

endmodule

// ----- src/usd_back.sv -----
// Back end: sequence decoding state, error and end handling, result register.
// Depends on usd_pkg; takes classified bytes from usd_queue.

module usd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  usd_pkg::token_t  head_token,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output usd_pkg::result_t result
);
  import usd_pkg::*;

  logic [20:0] accumulator;
  logic [1:0]  bytes_remaining;
  logic        error_seen;
  logic        terminated;

  logic [20:0] accumulator_next;
  logic [1:0]  bytes_remaining_next;
  logic        error_seen_next;
  logic        terminated_next;
  logic        got;
  logic [20:0] cp;
  logic        emit;
  result_t     result_next;
  logic        result_valid_next;
  logic [7:0]  b;
  logic        last;

  assign b    = head_token.octet.in_byte;
  assign last = head_token.octet.end_of_input;

  // take a byte whenever the result register is free or being drained
  assign pop = head_valid && (!result_valid || !result_stall);

  // decode one byte against the current sequence state
  always_comb begin
    accumulator_next     = accumulator;
    bytes_remaining_next = bytes_remaining;
    error_seen_next      = error_seen;
    terminated_next      = terminated;
    got                  = 1'b0;
    cp                   = '0;
    if (!error_seen && !terminated) begin
      if (bytes_remaining != 2'd0) begin
        accumulator_next     = {accumulator[14:0], b[5:0]};
        bytes_remaining_next = bytes_remaining - 2'd1;
        if (bytes_remaining_next == 2'd0) begin
          got              = 1'b1;
          cp               = accumulator_next;
          accumulator_next = '0;
        end
      end else begin
        case (head_token.lead)
          LEAD_ZERO:  terminated_next = 1'b1;
          LEAD_ASCII: begin
            got = 1'b1;
            cp  = {14'd0, b[6:0]};
          end
          LEAD_TWO: begin
            accumulator_next     = {16'd0, b[4:0]};
            bytes_remaining_next = 2'd1;
          end
          LEAD_THREE: begin
            accumulator_next     = {17'd0, b[3:0]};
            bytes_remaining_next = 2'd2;
          end
          LEAD_FOUR: begin
            accumulator_next     = {18'd0, b[2:0]};
            bytes_remaining_next = 2'd3;
          end
          default: error_seen_next = 1'b1;
        endcase
      end
    end
  end

  // build the result, with the error and end flags at the end of a string
  always_comb begin
    emit                          = got || last;
    result_next.code_point        = got ? cp : '0;
    result_next.has_code_point    = got;
    result_next.string_error      = last && (error_seen_next || (bytes_remaining_next != 2'd0));
    result_next.end_of_string     = last;
    if (pop) result_valid_next = emit;
    else if (!result_stall) result_valid_next = 1'b0;
    else result_valid_next = result_valid;
  end

  // hold decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      bytes_remaining <= '0;
      error_seen      <= 1'b0;
      terminated      <= 1'b0;
    end else if (pop) begin
      if (last) begin
        accumulator     <= '0;
        bytes_remaining <= '0;
        error_seen      <= 1'b0;
        terminated      <= 1'b0;
      end else begin
        accumulator     <= accumulator_next;
        bytes_remaining <= bytes_remaining_next;
        error_seen      <= error_seen_next;
        terminated      <= terminated_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      result <= result_next;
    end
  end

  a_mid_has_cp: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.end_of_string) |-> result.has_code_point)
    else $error("mid-string result without a code point");

  a_err_on_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.string_error) |-> result.end_of_string)
    else $error("error flag outside an end result");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (pop && last) |=> (bytes_remaining == 2'd0 && !error_seen && !terminated
                       && accumulator == '0))
    else $error("state not cleared after end of string");

  a_one_lead_state: assert property (@(posedge clk) disable iff (rst)
    terminated |-> (bytes_remaining == 2'd0 && !error_seen))
    else $error("terminated with a sequence or error pending");

endmodule

// ----- src/utf8_stream_decoder_unit.sv -----
// Top level of the UTF-8 stream decoder: front classifier, queue, back decoder.
// Depends on usd_pkg, usd_front, usd_queue and usd_back.
//
//   channel | signals                            | direction | payload
//   --------+------------------------------------+-----------+-------------------
//   octet   | octet_valid, octet_stall, octet    | in        | usd_pkg::octet_t
//   result  | result_valid, result_stall, result | out       | usd_pkg::result_t
//
// One byte per cycle sustained while the result side does not stall; each byte is
// written into the queue, then decoded into the back end's result register, from which
// its result is taken.
// Synchronous active-high reset empties the queue and clears the decoder state.
// The queue of QueueDepth entries lets bytes keep arriving while the result side stalls;
// octet_stall rises only when that queue is full.

module utf8_stream_decoder_unit #(
  parameter int QueueDepth = usd_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             octet_valid,
  output logic             octet_stall,
  input  usd_pkg::octet_t  octet,
  output logic             result_valid,
  input  logic             result_stall,
  output usd_pkg::result_t result
);
  import usd_pkg::*;

  logic   queue_full;
  logic   push;
  token_t push_token;
  logic   pop;
  logic   head_valid;
  token_t head_token;

  // classify and enqueue
  usd_front u_front (
    .octet_valid (octet_valid),
    .octet_stall (octet_stall),
    .octet       (octet),
    .queue_full  (queue_full),
    .push        (push),
    .push_token  (push_token)
  );

  // decouple front from back
  usd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_token (head_token)
  );

  // decode and deliver
  usd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_token   (head_token),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- tb/sv/utf8_stream_decoder_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the UTF-8 stream decoder: decodes every accepted byte on its own
// and compares the result channel against that prediction. Depends on usd_pkg.

module utf8_stream_decoder_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             octet_valid,
  input  logic             octet_stall,
  input  usd_pkg::octet_t  octet,
  input  logic             result_valid,
  input  logic             result_stall,
  input  usd_pkg::result_t result,
  output int               mismatch_count,
  output int               results_outstanding
);
  import usd_pkg::*;

  localparam int ReportLimit = 10;

  // decoder state as predicted from the accepted bytes
  logic [20:0] cp_accum;
  logic [1:0]  cont_left;
  logic        bad_lead_seen;
  logic        string_ended;

  result_t expected_results[$];
  result_t predicted;
  result_t oldest;
  logic    predicted_valid;

  task automatic clear_decoder();
    cp_accum      = '0;
    cont_left     = 2'd0;
    bad_lead_seen = 1'b0;
    string_ended  = 1'b0;
  endtask

  // advance the predicted decoder by one byte; set predicted_valid on a result
  task automatic decode_octet(input octet_t o);
    logic [7:0]  b;
    logic        got;
    logic [20:0] cp;
    b   = o.in_byte;
    got = 1'b0;
    cp  = '0;
    if (!bad_lead_seen && !string_ended) begin
      if (cont_left != 2'd0) begin
        // any byte here counts as a continuation, top bits unchecked
        cp_accum  = {cp_accum[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          got      = 1'b1;
          cp       = cp_accum;
          cp_accum = '0;
        end
      end else if (b == 8'h00) begin
        string_ended = 1'b1;
      end else begin
        casez (b)
          8'b0???????: begin
            got = 1'b1;
            cp  = {13'd0, b};
          end
          8'b110?????: begin
            cp_accum  = {16'd0, b[4:0]};
            cont_left = 2'd1;
          end
          8'b1110????: begin
            cp_accum  = {17'd0, b[3:0]};
            cont_left = 2'd2;
          end
          8'b11110???: begin
            cp_accum  = {18'd0, b[2:0]};
            cont_left = 2'd3;
          end
          default: bad_lead_seen = 1'b1;
        endcase
      end
    end
    predicted_valid          = got || o.end_of_input;
    predicted.code_point     = cp;
    predicted.has_code_point = got;
    // a sequence cut short by the last byte also marks the string bad
    predicted.string_error   = o.end_of_input && (bad_lead_seen || (cont_left != 2'd0));
    predicted.end_of_string  = o.end_of_input;
    if (o.end_of_input) clear_decoder();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_decoder();
      expected_results.delete();
      mismatch_count      = 0;
      results_outstanding = 0;
    end else begin
      // compare each result transaction with the oldest prediction
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("%0t: unexpected result cp=%06h has=%b err=%b eos=%b", $realtime,
                     result.code_point, result.has_code_point, result.string_error,
                     result.end_of_string);
        end else begin
          oldest = expected_results.pop_front();
          if (result.code_point !== oldest.code_point ||
              result.has_code_point !== oldest.has_code_point ||
              result.string_error !== oldest.string_error ||
              result.end_of_string !== oldest.end_of_string) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
              $display("%0t: mismatch exp cp=%06h h/e/e=%b%b%b got cp=%06h h/e/e=%b%b%b",
                       $realtime, oldest.code_point, oldest.has_code_point,
                       oldest.string_error, oldest.end_of_string, result.code_point,
                       result.has_code_point, result.string_error, result.end_of_string);
          end
        end
      end
      // predict from each accepted byte transaction
      if (octet_valid && !octet_stall) begin
        decode_octet(octet);
        if (predicted_valid) expected_results.push_back(predicted);
      end
      results_outstanding = expected_results.size();
    end
  end

endmodule

// ----- tb/sv/tb_utf8_stream_decoder_unit.sv -----
`timescale 1ns / 1ps
// Top of the UTF-8 stream decoder testbench: clock, reset, byte strings and result
// back-pressure. Depends on usd_pkg, utf8_stream_decoder_unit and the checker.

module tb_utf8_stream_decoder_unit;
  import usd_pkg::*;

  localparam int TotalOctets    = 1600;
  localparam int HoldAfter      = 500;
  localparam int PauseAfter     = 1000;
  localparam int QuietAfter     = 1400;
  localparam int LongHoldCycles = 300;
  localparam int CycleLimit     = 400000;
  localparam int DrainCycles    = 8;

  typedef enum int {
    FAULT_TRUNCATE,
    FAULT_BAD_LEAD,
    FAULT_ZERO,
    FAULT_SCRAMBLE
  } fault_t;

  logic    clk;
  logic    rst;
  logic    octet_valid;
  logic    octet_stall;
  octet_t  octet;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  int mismatch_count;
  int results_outstanding;
  int octets_sent;
  int cycle_count = 0;
  bit quiet;
  bit hold_request;

  logic [7:0] string_bytes[$];

  utf8_stream_decoder_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .octet_valid  (octet_valid),
    .octet_stall  (octet_stall),
    .octet        (octet),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  utf8_stream_decoder_checker u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .octet_valid         (octet_valid),
    .octet_stall         (octet_stall),
    .octet               (octet),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .result              (result),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // end the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // offer the bytes of string_bytes, end flag on the last; random gaps if asked
  task automatic send_string(input bit gaps);
    for (int i = 0; i < string_bytes.size(); i++) begin
      if (gaps && !quiet && $urandom_range(0, 5) == 0) begin
        octet_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      octet_valid <= 1'b1;
      octet       <= '{in_byte: string_bytes[i], end_of_input: (i == string_bytes.size() - 1)};
      do @(posedge clk); while (octet_stall);
      octets_sent++;
    end
  endtask

  // send one short string whose bytes are packed right-aligned in word
  task automatic send_directed(input logic [31:0] word, input int n);
    string_bytes.delete();
    for (int i = n - 1; i >= 0; i--) string_bytes.push_back(word[8*i +: 8]);
    send_string(1'b1);
  endtask

  initial begin : stimulus
    int          n;
    int          seq_len;
    int          pos;
    logic [20:0] cp;
    fault_t      fault;
    bit          hold_issued;
    bit          pause_done;

    rst          <= 1'b1;
    octet_valid  <= 1'b0;
    octet        <= '0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    hold_issued  = 1'b0;
    pause_done   = 1'b0;
    octets_sent  = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed strings: each lead class, extremes, and the corner cases
    send_directed(32'h41, 1);           // single ASCII byte that is also last
    send_directed(32'h7FC2A9, 3);       // last byte completes a two-byte sequence
    send_directed(32'hE282AC, 3);       // three-byte sequence
    send_directed(32'hF7BFBFBF, 4);     // four-byte sequence, all 21 bits set
    send_directed(32'h0041FF, 3);       // zero lead ends the string, rest ignored
    send_directed(32'h8041, 2);         // continuation byte in lead position
    send_directed(32'hF8, 1);           // 11111xxx lead
    send_directed(32'hE282, 2);         // sequence cut short by the last byte
    send_directed(32'hC300, 2);         // zero byte consumed as continuation
    send_directed(32'h00, 1);           // zero byte alone

    // random strings: mostly well formed, some broken, some noise
    while (octets_sent < TotalOctets) begin
      if (!hold_issued && octets_sent >= HoldAfter) begin
        hold_request = 1'b1;
        hold_issued  = 1'b1;
      end
      if (!pause_done && octets_sent >= PauseAfter) begin
        octet_valid <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0) @(posedge clk);
        pause_done = 1'b1;
      end
      quiet = (octets_sent >= QuietAfter);

      string_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 10);
        repeat (n) string_bytes.push_back(8'($urandom));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          seq_len = $urandom_range(1, 4);
          cp      = 21'($urandom);
          case (seq_len)
            1: string_bytes.push_back({1'b0, (cp[6:0] == 7'd0) ? 7'd1 : cp[6:0]});
            2: begin
              string_bytes.push_back({3'b110, cp[10:6]});
              string_bytes.push_back({2'b10, cp[5:0]});
            end
            3: begin
              string_bytes.push_back({4'b1110, cp[15:12]});
              string_bytes.push_back({2'b10, cp[11:6]});
              string_bytes.push_back({2'b10, cp[5:0]});
            end
            default: begin
              string_bytes.push_back({5'b11110, cp[20:18]});
              string_bytes.push_back({2'b10, cp[17:12]});
              string_bytes.push_back({2'b10, cp[11:6]});
              string_bytes.push_back({2'b10, cp[5:0]});
            end
          endcase
        end
        // break about a third of the well-formed strings
        if ($urandom_range(0, 2) == 0) begin
          pos   = $urandom_range(0, string_bytes.size() - 1);
          fault = fault_t'($urandom_range(0, 3));
          case (fault)
            FAULT_TRUNCATE:
              repeat ($urandom_range(1, 2))
                if (string_bytes.size() > 1) string_bytes.delete(string_bytes.size() - 1);
            FAULT_BAD_LEAD:
              string_bytes.insert(pos, $urandom_range(0, 1) ? 8'($urandom_range(128, 191))
                                                            : 8'($urandom_range(248, 255)));
            FAULT_ZERO:
              string_bytes.insert(pos, 8'h00);
            default:
              string_bytes[pos] = 8'($urandom);
          endcase
        end
      end
      send_string($urandom_range(0, 1) == 1);
    end
    octet_valid <= 1'b0;

    // drain, then give the verdict
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // result back-pressure: random stall bursts, one long hold on request
  initial begin : receiver
    int burst;
    result_stall <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_request) begin
        result_stall <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk);
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        burst = $urandom_range(1, 16);
        repeat (burst) @(posedge clk);
      end else begin
        result_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

endmodule

// ----- utf8_stream_decoder_unit.f -----
src/usd_pkg.sv
src/usd_front.sv
src/usd_queue.sv
src/usd_back.sv
src/utf8_stream_decoder_unit.sv
tb/sv/utf8_stream_decoder_checker.sv
tb/sv/tb_utf8_stream_decoder_unit.sv
